// ===== sv/mpnt_pkg.sv =====
package mpnt_pkg;

   // Size of the tracked map
   localparam int NUM_CHANNELS = 16;
   localparam int NUM_NOTES    = 128;

   // Request commands
   localparam logic [1:0] CMD_PASS  = 2'd0;
   localparam logic [1:0] CMD_FLUSH = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Register indexes of the control port
   localparam logic CSR_OVERRIDE_ENABLE  = 1'b0;
   localparam logic CSR_OVERRIDE_CHANNEL = 1'b1;

   // Message kinds seen by the parser
   localparam logic [2:0] KIND_NOTE_OFF      = 3'd0;
   localparam logic [2:0] KIND_NOTE_ON       = 3'd1;
   localparam logic [2:0] KIND_CTRL          = 3'd3;
   localparam logic [2:0] KIND_PROGRAM       = 3'd4;
   localparam logic [2:0] KIND_CHAN_PRESSURE = 3'd5;
   localparam logic [2:0] KIND_SYSTEM        = 3'd7;

   // System common bytes that carry data
   localparam logic [7:0] SYS_TIME_CODE = 8'hF1;
   localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
   localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;

   // Message bytes built by the flush
   localparam logic [3:0] NOTE_OFF_STATUS = 4'h8;
   localparam logic [3:0] CTRL_STATUS     = 4'hB;
   localparam logic [7:0] SUSTAIN_CTRL    = 8'd64;
   localparam logic [7:0] OFF_VELOCITY    = 8'd127;

   // Note map: rows of 16 notes, 8 rows per channel, then one controller slot
   localparam int        ROW_BITS   = 16;
   localparam int        ROW_COUNT  = 128;
   localparam logic [3:0] SEG_CTRL   = 4'd8;
   // 16 channels of 9 segments; the start segment is visited twice
   localparam logic [7:0] LAST_VISIT = 8'd144;

   typedef struct packed {
      logic       override_enable;
      logic [3:0] override_channel;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_FLUSH = 2'd1,
      OP_CLEAR = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  byte_val;
      logic        note_wr;
      logic        note_on;
      logic [3:0]  ch;
      logic [6:0]  note;
      logic        ctrl_wr;
      logic        ctrl_nz;
   } op_type;

   // Data bytes that follow a channel status of the given kind
   function automatic logic [1:0] data_len(input logic [2:0] kind);
      logic [1:0] len;
      case (kind)
         KIND_PROGRAM, KIND_CHAN_PRESSURE: len = 2'd1;
         default:                          len = 2'd2;
      endcase
      return len;
   endfunction

endpackage

// ===== sv/mpnt_if.sv =====
interface mpnt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] midi_byte;

   modport source (output valid, output cmd, output midi_byte, input ready);
   modport sink   (input valid, input cmd, input midi_byte, output ready);
endinterface

interface mpnt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       flush_done;

   modport source (output valid, output out_byte, output last, output flush_done,
                   input ready);
   modport sink   (input valid, input out_byte, input last, input flush_done,
                   output ready);
endinterface

// ===== sv/midi_playback_note_tracker_unit.sv =====
// MIDI playback note tracker.
// req_ch carries a command and a MIDI byte; a transfer is taken when valid and
// ready are both high. rsp_ch returns the bytes to transmit, with last on the
// final byte of each request and flush_done when a flush found nothing left.
// csr_we/csr_index/csr_wdata set the channel override; write it while idle.
// A pass request gives one byte; when it updates the note map, the back end
// first does one read-modify-write of a 16-note row. The back end takes the
// next queued request only when the previous one is done. A flush step scans
// one row or one controller slot at a time through the row memory's registered
// read port, at most 145 segments; its first byte is followed by the other two
// bytes of a three-byte message, one a cycle while the receiver is ready, or a
// single done byte is given. A clear gives nothing. The input side takes one
// request per cycle, while the two-entry queue has room, as earlier work runs.
// A stalled receiver holds the response register; the queue then fills and
// ready falls. Reset empties the note map at once through per-row valid bits,
// zeroes sustain state, parser and flush cursor; no clearing pass.
module midi_playback_note_tracker_unit
   import mpnt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mpnt_req_if.sink   req_ch,
   mpnt_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [3:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full;
   logic    q_push;
   op_type  push_op;
   logic    q_pop;
   logic    q_valid;
   op_type  pop_op;

   // Take control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OVERRIDE_ENABLE:  cfg_in.override_enable  = csr_wdata[0];
            CSR_OVERRIDE_CHANNEL: cfg_in.override_channel = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpnt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_push (q_push),
      .q_op   (push_op)
   );

   mpnt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (push_op),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_op    (pop_op)
   );

   mpnt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_op    (pop_op),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== sv/mpnt_front.sv =====
module mpnt_front
   import mpnt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mpnt_req_if.sink      req_ch,
   input  cfg_type       cfg,
   input  logic          q_full,
   output logic          q_push,
   output op_type        q_op
);

   localparam logic [4:0] NC = 5'(NUM_CHANNELS);
   localparam logic [7:0] NN = 8'(NUM_NOTES);

   logic [2:0] status_kind_ff, status_kind_in;
   logic [3:0] cur_channel_ff, cur_channel_in;
   logic [1:0] data_count_ff, data_count_in;
   logic [1:0] data_left_ff, data_left_in;
   logic [6:0] held_note_ff, held_note_in;

   logic       accept;
   logic [1:0] left_base;
   logic [1:0] left_next;
   logic [3:0] ch_sel;
   logic [7:0] b;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.midi_byte;
   assign left_base    = (data_left_ff == 2'd0) ? data_count_ff : data_left_ff;
   assign left_next    = left_base - 2'd1;
   assign ch_sel       = cfg.override_enable ? cfg.override_channel : b[3:0];

   // Classify the transfer and follow running status
   always_comb begin
      status_kind_in = status_kind_ff;
      cur_channel_in = cur_channel_ff;
      data_count_in  = data_count_ff;
      data_left_in   = data_left_ff;
      held_note_in   = held_note_ff;
      q_push         = 1'b0;
      q_op           = '{kind: OP_BYTE, byte_val: b, note_wr: 1'b0, note_on: 1'b0,
                         ch: cur_channel_ff, note: held_note_ff, ctrl_wr: 1'b0,
                         ctrl_nz: (b[6:0] != 7'd0)};
      if (accept) begin
         case (req_ch.cmd)
            CMD_PASS: begin
               q_push = 1'b1;
               if (!b[7]) begin
                  // data byte
                  if (data_count_ff != 2'd0) begin
                     data_left_in = left_next;
                     if (status_kind_ff == KIND_NOTE_OFF || status_kind_ff == KIND_NOTE_ON) begin
                        if (left_next == 2'd1) begin
                           held_note_in = b[6:0];
                        end
                        if (left_next == 2'd0 && {1'b0, cur_channel_ff} < NC
                            && {1'b0, held_note_ff} < NN) begin
                           q_op.note_wr = 1'b1;
                           q_op.note_on = (status_kind_ff == KIND_NOTE_ON) && (b != 8'd0);
                        end
                     end else if (status_kind_ff == KIND_CTRL && left_next == 2'd0
                                  && {1'b0, cur_channel_ff} < NC) begin
                        q_op.ctrl_wr = 1'b1;
                     end
                  end
               end else if (b[7:3] == 5'b11111) begin
                  // real-time byte: parser untouched
               end else if (b[7:4] == 4'hF) begin
                  status_kind_in = KIND_SYSTEM;
                  if (b == SYS_TIME_CODE || b == SYS_SONG_SEL) begin
                     data_count_in = 2'd1;
                  end else if (b == SYS_SONG_POS) begin
                     data_count_in = 2'd2;
                  end else begin
                     data_count_in = 2'd0;
                  end
                  data_left_in = data_count_in;
               end else begin
                  status_kind_in = b[6:4];
                  cur_channel_in = ch_sel;
                  data_count_in  = data_len(b[6:4]);
                  data_left_in   = data_count_in;
                  q_op.byte_val  = {b[7:4], ch_sel};
               end
            end
            CMD_FLUSH: begin
               q_push     = 1'b1;
               q_op.kind  = OP_FLUSH;
            end
            CMD_CLEAR: begin
               q_push     = 1'b1;
               q_op.kind  = OP_CLEAR;
            end
            default: begin
               // unused command: drop
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_kind_ff <= 3'd0;
         cur_channel_ff <= 4'd0;
         data_count_ff  <= 2'd0;
         data_left_ff   <= 2'd0;
         held_note_ff   <= 7'd0;
      end else begin
         status_kind_ff <= status_kind_in;
         cur_channel_ff <= cur_channel_in;
         data_count_ff  <= data_count_in;
         data_left_ff   <= data_left_in;
         held_note_ff   <= held_note_in;
      end
   end

endmodule

// ===== sv/mpnt_queue.sv =====
module mpnt_queue
   import mpnt_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   pop_valid,
   output op_type pop_op
);

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_op    = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued operations
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== sv/mpnt_back.sv =====
module mpnt_back
   import mpnt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  op_type    q_op,
   output logic      q_pop,
   mpnt_rsp_if.source rsp_ch
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_RMW       = 5'b00010,
      ST_SEND      = 5'b00100,
      ST_SCAN_RD   = 5'b01000,
      ST_SCAN_EVAL = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;

   // Note map memory and per-row valid bits
   logic [ROW_BITS-1:0] note_mem [ROW_COUNT];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic                rd_vld_ff;
   logic [6:0]          rd_row;
   logic                mem_we;
   logic [ROW_BITS-1:0] mem_wdata;

   logic [ROW_COUNT-1:0] row_vld_ff, row_vld_in;
   logic [15:0]          ctrl_nz_ff, ctrl_nz_in;

   logic [6:0] wr_row_ff, wr_row_in;
   logic [3:0] wr_bit_ff, wr_bit_in;
   logic       wr_on_ff, wr_on_in;

   // Flush cursor and scan position
   logic [3:0] cur_ch_ff, cur_ch_in;
   logic [3:0] cur_seg_ff, cur_seg_in;
   logic [3:0] cur_off_ff, cur_off_in;
   logic [3:0] scan_ch_ff, scan_ch_in;
   logic [3:0] scan_seg_ff, scan_seg_in;
   logic [7:0] visit_ff, visit_in;

   // Bytes waiting to go out
   logic [2:0][7:0] emit_b_ff, emit_b_in;
   logic [1:0]      emit_n_ff, emit_n_in;
   logic [1:0]      emit_idx_ff, emit_idx_in;
   logic            emit_done_ff, emit_done_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_done_ff, rsp_done_in;

   logic                slot_free;
   logic [ROW_BITS-1:0] rd_bits;
   logic [ROW_BITS-1:0] seg_bits;
   logic [ROW_BITS-1:0] lo_mask;
   logic [ROW_BITS-1:0] scan_mask;
   logic [ROW_BITS-1:0] cand;
   logic                hit;
   logic [3:0]          hit_bit;

   function automatic logic [3:0] first_set(input logic [ROW_BITS-1:0] v);
      logic [3:0] idx;
      idx = 4'd0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign rd_bits   = rd_data_ff & {ROW_BITS{rd_vld_ff}};
   assign rd_row    = (state_ff == ST_IDLE) ? {q_op.ch, q_op.note[6:4]}
                                            : {scan_ch_ff, scan_seg_ff[2:0]};

   // Evaluate the segment under scan
   always_comb begin
      if (scan_seg_ff == SEG_CTRL) begin
         seg_bits = {{(ROW_BITS-1){1'b0}}, ctrl_nz_ff[scan_ch_ff]};
      end else begin
         seg_bits = rd_bits;
      end
      lo_mask = {ROW_BITS{1'b1}} << cur_off_ff;
      if (visit_ff == 8'd0) begin
         scan_mask = lo_mask;
      end else if (visit_ff == LAST_VISIT) begin
         scan_mask = ~lo_mask;
      end else begin
         scan_mask = {ROW_BITS{1'b1}};
      end
      cand    = seg_bits & scan_mask;
      hit     = |cand;
      hit_bit = first_set(cand);
   end

   // Sequence the operations
   always_comb begin
      state_in     = state_ff;
      row_vld_in   = row_vld_ff;
      ctrl_nz_in   = ctrl_nz_ff;
      wr_row_in    = wr_row_ff;
      wr_bit_in    = wr_bit_ff;
      wr_on_in     = wr_on_ff;
      cur_ch_in    = cur_ch_ff;
      cur_seg_in   = cur_seg_ff;
      cur_off_in   = cur_off_ff;
      scan_ch_in   = scan_ch_ff;
      scan_seg_in  = scan_seg_ff;
      visit_in     = visit_ff;
      emit_b_in    = emit_b_ff;
      emit_n_in    = emit_n_ff;
      emit_idx_in  = emit_idx_ff;
      emit_done_in = emit_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = rd_bits;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_op.kind)
                  OP_BYTE: begin
                     emit_b_in[0] = q_op.byte_val;
                     emit_n_in    = 2'd1;
                     emit_idx_in  = 2'd0;
                     emit_done_in = 1'b0;
                     if (q_op.ctrl_wr) begin
                        ctrl_nz_in[q_op.ch] = q_op.ctrl_nz;
                     end
                     wr_row_in = {q_op.ch, q_op.note[6:4]};
                     wr_bit_in = q_op.note[3:0];
                     wr_on_in  = q_op.note_on;
                     state_in  = q_op.note_wr ? ST_RMW : ST_SEND;
                  end
                  OP_FLUSH: begin
                     scan_ch_in  = cur_ch_ff;
                     scan_seg_in = cur_seg_ff;
                     visit_in    = 8'd0;
                     state_in    = ST_SCAN_RD;
                  end
                  OP_CLEAR: begin
                     row_vld_in = '0;
                     ctrl_nz_in = '0;
                     cur_ch_in  = 4'd0;
                     cur_seg_in = 4'd0;
                     cur_off_in = 4'd0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RMW: begin
            // modify one note of the row read last cycle
            mem_we               = 1'b1;
            mem_wdata[wr_bit_ff] = wr_on_ff;
            row_vld_in[wr_row_ff] = 1'b1;
            state_in             = ST_SEND;
         end
         ST_SEND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = emit_b_ff[emit_idx_ff];
               rsp_last_in  = (emit_idx_ff == emit_n_ff - 2'd1);
               rsp_done_in  = emit_done_ff;
               emit_idx_in  = emit_idx_ff + 2'd1;
               if (emit_idx_ff == emit_n_ff - 2'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN_RD: begin
            wr_row_in = {scan_ch_ff, scan_seg_ff[2:0]};
            state_in  = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            emit_idx_in  = 2'd0;
            emit_done_in = 1'b0;
            emit_n_in    = 2'd3;
            if (hit && scan_seg_ff != SEG_CTRL) begin
               // note-off for the first sounding note
               mem_we             = 1'b1;
               mem_wdata[hit_bit] = 1'b0;
               emit_b_in[0]       = {NOTE_OFF_STATUS, scan_ch_ff};
               emit_b_in[1]       = {1'b0, scan_seg_ff[2:0], hit_bit};
               emit_b_in[2]       = OFF_VELOCITY;
               cur_ch_in          = scan_ch_ff;
               if (hit_bit == 4'd15) begin
                  cur_seg_in = scan_seg_ff + 4'd1;
                  cur_off_in = 4'd0;
               end else begin
                  cur_seg_in = scan_seg_ff;
                  cur_off_in = hit_bit + 4'd1;
               end
               state_in = ST_SEND;
            end else if (hit) begin
               // sustain off for the channel
               ctrl_nz_in[scan_ch_ff] = 1'b0;
               emit_b_in[0]           = {CTRL_STATUS, scan_ch_ff};
               emit_b_in[1]           = SUSTAIN_CTRL;
               emit_b_in[2]           = 8'd0;
               cur_ch_in              = scan_ch_ff + 4'd1;
               cur_seg_in             = 4'd0;
               cur_off_in             = 4'd0;
               state_in               = ST_SEND;
            end else if (visit_ff == LAST_VISIT) begin
               // nothing left: report done
               emit_b_in[0] = 8'd0;
               emit_n_in    = 2'd1;
               emit_done_in = 1'b1;
               cur_ch_in    = 4'd0;
               cur_seg_in   = 4'd0;
               cur_off_in   = 4'd0;
               state_in     = ST_SEND;
            end else begin
               if (scan_seg_ff == SEG_CTRL) begin
                  scan_ch_in  = scan_ch_ff + 4'd1;
                  scan_seg_in = 4'd0;
               end else begin
                  scan_seg_in = scan_seg_ff + 4'd1;
               end
               visit_in = visit_ff + 8'd1;
               state_in = ST_SCAN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_vld_ff   <= '0;
         ctrl_nz_ff   <= '0;
         cur_ch_ff    <= 4'd0;
         cur_seg_ff   <= 4'd0;
         cur_off_ff   <= 4'd0;
         scan_ch_ff   <= 4'd0;
         scan_seg_ff  <= 4'd0;
         visit_ff     <= 8'd0;
         emit_n_ff    <= 2'd1;
         emit_idx_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_vld_ff   <= row_vld_in;
         ctrl_nz_ff   <= ctrl_nz_in;
         cur_ch_ff    <= cur_ch_in;
         cur_seg_ff   <= cur_seg_in;
         cur_off_ff   <= cur_off_in;
         scan_ch_ff   <= scan_ch_in;
         scan_seg_ff  <= scan_seg_in;
         visit_ff     <= visit_in;
         emit_n_ff    <= emit_n_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wr_row_ff    <= wr_row_in;
      wr_bit_ff    <= wr_bit_in;
      wr_on_ff     <= wr_on_in;
      emit_b_ff    <= emit_b_in;
      emit_done_ff <= emit_done_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // Row memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[wr_row_ff] <= mem_wdata;
      end
      rd_data_ff <= note_mem[rd_row];
      rd_vld_ff  <= row_vld_ff[rd_row];
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = rsp_byte_ff;
   assign rsp_ch.last       = rsp_last_ff;
   assign rsp_ch.flush_done = rsp_done_ff;

   a_hit_sends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_EVAL && hit) |=> (state_ff == ST_SEND))
      else $error("scan hit did not move to send");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (emit_idx_ff < emit_n_ff))
      else $error("emit index beyond byte count");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_last_ff)
      else $error("flush done without last");

   a_visit_bound: assert property (@(posedge clock) disable iff (reset)
      visit_ff <= LAST_VISIT)
      else $error("scan ran past its final segment");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff != ST_RMW || $past(q_op.note_wr)))
      else $error("read-modify-write without a note update");

endmodule

// ===== verif/midi_playback_note_tracker_unit_checker.sv =====
`timescale 1ns / 1ps

module midi_playback_note_tracker_unit_checker
   import mpnt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mpnt_req_if        req_ch,
   mpnt_rsp_if        rsp_ch,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [3:0] csr_wdata,
   output int         fail_count,
   output int         bytes_owed
);

   localparam int CHANNELS   = 16;
   localparam int NOTES      = 128;
   localparam int SCAN_SLOTS = CHANNELS * (NOTES + 1);

   localparam logic [7:0] SYSTEM_BASE        = 8'hF0;
   localparam logic [7:0] REALTIME_BASE      = 8'hF8;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       flush_done;
   } tx_byte_type;

   // Tracker state as the block should hold it
   logic        force_en;
   logic [3:0]  force_ch;
   bit          sounding [0:CHANNELS*NOTES-1];
   logic [6:0]  sustain_val [0:CHANNELS-1];
   logic [2:0]  kind;
   logic [3:0]  chan;
   logic [1:0]  data_total;
   logic [1:0]  data_left;
   logic [6:0]  held_note;
   logic [11:0] scan_pos;
   tx_byte_type owed_q[$];

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic void owe(input logic [7:0] b, input logic last, input logic done);
      tx_byte_type t;
      t.out_byte   = b;
      t.last       = last;
      t.flush_done = done;
      owed_q.push_back(t);
   endfunction

   function automatic void clear_store();
      for (int i = 0; i < CHANNELS * NOTES; i++) sounding[i] = 1'b0;
      for (int c = 0; c < CHANNELS; c++) sustain_val[c] = '0;
      scan_pos = '0;
   endfunction

   function automatic void reset_tracker();
      force_en   = 1'b0;
      force_ch   = '0;
      kind       = '0;
      chan       = '0;
      data_total = '0;
      data_left  = '0;
      held_note  = '0;
      clear_store();
   endfunction

   // Count a data byte against the current status and update notes or sustain
   function automatic void take_data(input logic [7:0] b);
      if (data_total == 2'd0) return;
      if (data_left == 2'd0) data_left = data_total;
      data_left = data_left - 2'd1;
      if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) begin
         if (data_left == 2'd1) held_note = b[6:0];
         if (data_left == 2'd0)
            sounding[chan * NOTES + held_note] = (kind == KIND_NOTE_ON && b != 8'd0);
      end else if (kind == KIND_CTRL && data_left == 2'd0) begin
         sustain_val[chan] = b[6:0];
      end
   endfunction

   function automatic logic [7:0] played_byte(input logic [7:0] b);
      if (!b[7]) begin
         take_data(b);
         return b;
      end
      // real-time bytes leave the parser alone
      if (b >= REALTIME_BASE) return b;
      if (b >= SYSTEM_BASE) begin
         kind = KIND_SYSTEM;
         if (b == SYS_TIME_CODE || b == SYS_SONG_SEL) data_total = 2'd1;
         else if (b == SYS_SONG_POS)                 data_total = 2'd2;
         else                                        data_total = 2'd0;
         data_left = data_total;
         return b;
      end
      kind       = b[6:4];
      chan       = force_en ? force_ch : b[3:0];
      data_total = (kind == KIND_PROGRAM || kind == KIND_CHAN_PRESSURE) ? 2'd1 : 2'd2;
      data_left  = data_total;
      return {b[7:4], chan};
   endfunction

   // Scan from the cursor for the next sounding note or held sustain, wrapping once
   function automatic void flush_next();
      int start;
      int pos;
      int ch;
      int k;
      start = (scan_pos < SCAN_SLOTS) ? int'(scan_pos) : 0;
      for (int i = 0; i < SCAN_SLOTS; i++) begin
         pos = (start + i) % SCAN_SLOTS;
         ch  = pos / (NOTES + 1);
         k   = pos % (NOTES + 1);
         if (k < NOTES) begin
            if (sounding[ch * NOTES + k]) begin
               sounding[ch * NOTES + k] = 1'b0;
               scan_pos = 12'(pos + 1);
               owe({NOTE_OFF_STATUS, 4'(ch)}, 1'b0, 1'b0);
               owe(8'(k), 1'b0, 1'b0);
               owe(OFF_VELOCITY, 1'b1, 1'b0);
               return;
            end
         end else if (sustain_val[ch] != 7'd0) begin
            sustain_val[ch] = '0;
            scan_pos = 12'(pos + 1);
            owe({CTRL_STATUS, 4'(ch)}, 1'b0, 1'b0);
            owe(SUSTAIN_CTRL, 1'b0, 1'b0);
            owe(8'd0, 1'b1, 1'b0);
            return;
         end
      end
      scan_pos = '0;
      owe(8'd0, 1'b1, 1'b1);
   endfunction

   // Predict on every request transfer, compare on every response transfer
   always @(posedge clock) begin
      tx_byte_type want;
      if (reset) begin
         reset_tracker();
         owed_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_OVERRIDE_ENABLE) force_en = csr_wdata[0];
            else                                  force_ch = csr_wdata;
         end
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.cmd)
               CMD_PASS:  owe(played_byte(req_ch.midi_byte), 1'b1, 1'b0);
               CMD_FLUSH: flush_next();
               CMD_CLEAR: clear_store();
               default:   ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_q.size() == 0) begin
               report("unexpected byte", rsp_ch.out_byte, 8'd0);
            end else begin
               want = owed_q.pop_front();
               if (rsp_ch.out_byte !== want.out_byte)
                  report("out_byte", rsp_ch.out_byte, want.out_byte);
               if (rsp_ch.last !== want.last)
                  report("last", 8'(rsp_ch.last), 8'(want.last));
               if (rsp_ch.flush_done !== want.flush_done)
                  report("flush_done", 8'(rsp_ch.flush_done), 8'(want.flush_done));
            end
         end
      end
      bytes_owed = owed_q.size();
   end

endmodule

// ===== verif/midi_playback_note_tracker_unit_tb.sv =====
`timescale 1ns / 1ps

module midi_playback_note_tracker_unit_tb
   import mpnt_pkg::*;
();

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         SEGMENT_LEN  = 56;

   // Status nibbles of the channel messages
   localparam logic [3:0] ST_NOTE_ON    = 4'h9;
   localparam logic [3:0] ST_POLY       = 4'hA;
   localparam logic [3:0] ST_PROGRAM    = 4'hC;
   localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
   localparam logic [3:0] ST_BEND       = 4'hE;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [3:0] csr_wdata;
   int         fail_count;
   int         bytes_owed;
   int         send_idle_pct;
   int         stall_pct;
   int         items_sent;
   int         cycle_count = 0;

   mpnt_req_if req_ch ();
   mpnt_rsp_if rsp_ch ();

   midi_playback_note_tracker_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   midi_playback_note_tracker_unit_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .bytes_owed (bytes_owed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response side at the rate of the current phase
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Entered and left just after a falling edge; valid stays high for the next call
   task automatic send_req(input logic [1:0] cmd, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= cmd;
      req_ch.midi_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (cmd != CMD_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed byte has been seen and the block is quiet
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (bytes_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_config(input logic en, input logic [3:0] ch);
      csr_we    <= 1'b1;
      csr_index <= CSR_OVERRIDE_ENABLE;
      csr_wdata <= {3'b000, en};
      @(negedge clock);
      csr_index <= CSR_OVERRIDE_CHANNEL;
      csr_wdata <= ch;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_data_byte();
      // now and then slip a real-time byte into the message
      if ($urandom_range(9) == 0) send_req(CMD_PASS, {5'b11111, 3'($urandom_range(7))});
      if ($urandom_range(3) == 0) send_req(CMD_PASS, 8'd0);
      else if ($urandom_range(1) == 0) send_req(CMD_PASS, 8'($urandom_range(60, 67)));
      else send_req(CMD_PASS, {1'b0, 7'($urandom_range(127))});
   endtask

   // Mostly well-formed messages with random content, the rest commands and noise
   task automatic play_random_message();
      int         pick;
      int         count;
      logic [3:0] hi;
      logic [7:0] sys;
      pick = $urandom_range(99);
      if (pick < 60) begin
         case ($urandom_range(11))
            0, 1, 2, 3: hi = ST_NOTE_ON;
            4, 5:       hi = NOTE_OFF_STATUS;
            6, 7:       hi = CTRL_STATUS;
            8:          hi = ST_POLY;
            9:          hi = ST_PROGRAM;
            10:         hi = ST_CHAN_PRESS;
            default:    hi = ST_BEND;
         endcase
         // leave out the status now and then to lean on running status
         if ($urandom_range(3) != 0) send_req(CMD_PASS, {hi, 4'($urandom_range(15))});
         count = (hi == ST_PROGRAM || hi == ST_CHAN_PRESS) ? 1 : 2;
         repeat (count) send_data_byte();
      end else if (pick < 68) begin
         send_req(CMD_PASS, {5'b11111, 3'($urandom_range(7))});
      end else if (pick < 75) begin
         sys = {5'b11110, 3'($urandom_range(7))};
         send_req(CMD_PASS, sys);
         if (sys == SYS_TIME_CODE || sys == SYS_SONG_SEL) send_data_byte();
         else if (sys == SYS_SONG_POS) repeat (2) send_data_byte();
      end else if (pick < 87) begin
         repeat ($urandom_range(1, 4)) send_req(CMD_FLUSH, 8'($urandom()));
      end else if (pick < 90) begin
         send_req(CMD_CLEAR, 8'($urandom()));
      end else if (pick < 93) begin
         send_req(CMD_UNUSED, 8'($urandom()));
      end else begin
         send_req(CMD_PASS, 8'($urandom()));
      end
   endtask

   task automatic run_segment(input logic en, input logic [3:0] ch, input int idle_pct,
                              input int stall, input bit drain_midway);
      int  target;
      bit  drained;
      wait_idle();
      write_config(en, ch);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      target        = items_sent + SEGMENT_LEN;
      drained       = 1'b0;
      while (items_sent < target) begin
         if (drain_midway && !drained && items_sent >= target - SEGMENT_LEN / 2) begin
            wait_idle();
            drained = 1'b1;
         end
         play_random_message();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_PASS;
      req_ch.midi_byte = 8'd0;
      csr_we           = 1'b0;
      csr_index        = CSR_OVERRIDE_ENABLE;
      csr_wdata        = 4'd0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      items_sent       = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // data ahead of any status byte goes through untracked
      send_req(CMD_PASS, 8'h00);
      // notes on at both corners of the map
      send_req(CMD_PASS, 8'h90);
      send_req(CMD_PASS, 8'h00);
      send_req(CMD_PASS, 8'h7F);
      send_req(CMD_PASS, 8'h9F);
      send_req(CMD_PASS, 8'h7F);
      send_req(CMD_PASS, 8'h01);
      // real-time byte, then running status note on at zero velocity turns it off
      send_req(CMD_PASS, 8'hF8);
      send_req(CMD_PASS, 8'h7F);
      send_req(CMD_PASS, 8'h00);
      // sustain held on a middle channel
      send_req(CMD_PASS, 8'hB7);
      send_req(CMD_PASS, 8'h40);
      send_req(CMD_PASS, 8'h7F);
      // poly pressure takes two data bytes, channel pressure one
      send_req(CMD_PASS, 8'hA3);
      send_req(CMD_PASS, 8'h10);
      send_req(CMD_PASS, 8'h20);
      send_req(CMD_PASS, 8'hD4);
      send_req(CMD_PASS, 8'h05);
      // system common with data, then the top real-time byte
      send_req(CMD_PASS, 8'hF2);
      send_req(CMD_PASS, 8'h11);
      send_req(CMD_PASS, 8'h22);
      send_req(CMD_PASS, 8'hFF);
      // flush the note, the sustain, then find nothing left
      repeat (3) send_req(CMD_FLUSH, 8'h00);
      send_req(CMD_CLEAR, 8'hFF);
      send_req(CMD_UNUSED, 8'hAA);

      run_segment(1'b0, 4'd0, 0, 0, 1'b0);
      run_segment(1'b1, 4'd15, 66, 0, 1'b0);
      run_segment(1'b1, 4'd0, 0, 66, 1'b0);
      run_segment(1'b0, 4'($urandom_range(15)), 8, 8, 1'b0);
      run_segment(1'b1, 4'($urandom_range(1, 14)), 0, 0, 1'b1);

      wait_idle();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
